>>> rtl/rbma_pkg.sv
package rbma_pkg;

    // Fixed field widths of the stream words
    localparam int SAMPLE_W    = 16;
    localparam int AVG_W       = 24;
    localparam int CNT_OUT_W   = 5;
    localparam int FRAC_W      = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;
    localparam int DEPTH_DEF   = 16;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> rtl/rbma_ram.sv
module rbma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ring_buffer_moving_average_core.sv
// Moving average over a ring of the last DEPTH signed 16-bit samples.
//
// Input channel (s_*): one word per item. s_tuser selects the kind: a new
// sample, or a clear that resets write pointer, sum and count and returns nothing.
// s_tdata carries the sample, ignored on a clear.
// Result channel (m_*): one word per sample with the mean (8 fraction
// bits, truncated toward zero), the held count, and the full flag in
// m_tuser.
//
// A sample goes from accept to result in these steps: the ring read happens
// at the accept edge, then the read-modify-write of ring and sum, one step
// per dividend bit in the restoring divider, and the load of the output
// register. The input reopens after that, so the block takes one item at a
// time and accepts no new sample before the last result is loaded; the
// divider sets the rate. A clear leaves the sequencer idle.
//
// Reset (aresetn low, synchronous) empties the window and drops any pending
// result; ring contents are left as they are and are only read once written.
// When the receiver stalls, the result holds in the output register while
// the next item is accepted and worked on; a second result waits in the
// sequencer until the output register frees up.
module ring_buffer_moving_average_core #(
    parameter int DEPTH = rbma_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rbma_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] sample
    input  logic                           s_tuser,  // [0] kind
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rbma_pkg::M_TDATA_W-1:0] m_tdata,  // [23:0] average, [28:24] held_count
    output logic                           m_tuser   // [0] full_res
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // sum of DEPTH samples plus sign
    localparam int SUM_W  = rbma_pkg::SAMPLE_W + PTR_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int DVD_W  = MAG_W + rbma_pkg::FRAC_W;
    localparam int STEP_W = $clog2(DVD_W);
    localparam int PAD_W  = rbma_pkg::M_TDATA_W - rbma_pkg::AVG_W - rbma_pkg::CNT_OUT_W;

    rbma_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0]         wp_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [rbma_pkg::SAMPLE_W-1:0] sample_reg;

    // divider
    logic [DVD_W-1:0]         dvd_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         div_reg;
    logic                     neg_reg;
    logic [STEP_W-1:0]        step_reg;

    // output register
    logic                           m_tvalid_reg;
    logic [rbma_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;

    logic s_accept, s_clear, s_sample;
    logic full;
    logic ram_re, ram_we, out_load, div_last;
    logic [rbma_pkg::SAMPLE_W-1:0] ram_rdata;
    logic signed [SUM_W-1:0] old_ext, new_ext, sum_next;
    logic [SUM_W-1:0]        sum_abs;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W:0]          trial;
    logic                    trial_ge;
    logic [DVD_W-1:0]        quot_signed;

    assign s_accept = s_tvalid && s_tready;
    assign s_clear  = s_accept && (s_tuser == rbma_pkg::KIND_CLEAR);
    assign s_sample = s_accept && (s_tuser == rbma_pkg::KIND_SAMPLE);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign div_last = (step_reg == STEP_W'(DVD_W - 1));

    // ---------------------------------------------------------------
    // Ring store: read the slot at accept, write the new sample back
    // in the next cycle. One item at a time, so the two never collide.
    // ---------------------------------------------------------------
    rbma_ram #(
        .WIDTH (rbma_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rbma_pkg::ST_IDLE: begin
                if (s_sample) begin
                    state_next = rbma_pkg::ST_RMW;
                end
            end
            rbma_pkg::ST_RMW: state_next = rbma_pkg::ST_DIV;
            rbma_pkg::ST_DIV: begin
                if (div_last) begin
                    state_next = rbma_pkg::ST_OUT;
                end
            end
            rbma_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = rbma_pkg::ST_IDLE;
                end
            end
            default: state_next = rbma_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            rbma_pkg::ST_IDLE: s_tready = 1'b1;
            rbma_pkg::ST_RMW:  ram_we   = 1'b1;
            rbma_pkg::ST_DIV:  ;
            rbma_pkg::ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign ram_re = s_sample;

    // ---------------------------------------------------------------
    // Running sum update: drop the overwritten sample once full
    // ---------------------------------------------------------------
    always_comb begin
        old_ext    = full ? SUM_W'(signed'(ram_rdata)) : '0;
        new_ext    = SUM_W'(signed'(sample_reg));
        sum_next   = sum_reg - old_ext + new_ext;
        sum_abs    = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
        count_next = full ? count_reg : count_reg + CNT_W'(1);
    end

    // restoring divide step: one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        trial_ge = (trial >= {1'b0, div_reg});
    end

    assign quot_signed = neg_reg ? DVD_W'(-dvd_reg) : dvd_reg;

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbma_pkg::ST_IDLE;
            wp_reg    <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_clear) begin
                wp_reg    <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
            end else if (state_reg == rbma_pkg::ST_RMW) begin
                wp_reg    <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload and divider datapath
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_sample) begin
            sample_reg <= s_tdata;
        end
        case (state_reg)
            rbma_pkg::ST_RMW: begin
                // dividend = |sum| * 256
                dvd_reg  <= {sum_abs[MAG_W-1:0], {rbma_pkg::FRAC_W{1'b0}}};
                rem_reg  <= '0;
                div_reg  <= count_next;
                neg_reg  <= sum_next[SUM_W-1];
                step_reg <= '0;
            end
            rbma_pkg::ST_DIV: begin
                rem_reg  <= trial_ge ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
                dvd_reg  <= {dvd_reg[DVD_W-2:0], trial_ge};
                step_reg <= step_reg + STEP_W'(1);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register: hold the result until the receiver takes it
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}},
                            rbma_pkg::CNT_OUT_W'(count_reg),
                            quot_signed[rbma_pkg::AVG_W-1:0]};
            m_tuser_reg <= full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("held count exceeds ring depth");

    a_fill_pointer: assert property (@(posedge aclk) disable iff (!aresetn)
        !full |-> (CNT_W'(wp_reg) == count_reg))
        else $error("write pointer out of step with count while filling");

    a_rmw_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == rbma_pkg::ST_RMW) |-> $past(ram_re))
        else $error("ring update without a preceding read");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rbma_pkg::ST_DIV) |-> (div_reg != '0))
        else $error("divide by zero count");

endmodule

>>> tb/tb.sv
// Testbench for ring_buffer_moving_average_core.
//
// Input words go in through the s_* stream. A clear word (s_tuser high)
// empties the window and yields no result. A sample word updates the window
// and yields one result word. Each accepted input word is also run through a
// local window model here, which queues the result it should produce. A
// monitor pops that queue for every accepted result word and compares
// average, held count, padding and full flag. The sender works in random
// bursts with gaps between them. The receiver stalls on its own pattern, and
// at least once it holds off long enough to back the block up into its input.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH       = rbma_pkg::DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_WORDS    = 1500;

    typedef struct packed {
        logic [rbma_pkg::AVG_W-1:0]     average;
        logic [rbma_pkg::CNT_OUT_W-1:0] held_count;
        logic                           full;
    } mean_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rbma_pkg::S_TDATA_W-1:0] s_tdata;   // [15:0] sample
    logic                           s_tuser;   // [0] kind
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rbma_pkg::M_TDATA_W-1:0] m_tdata;   // [23:0] average, [28:24] held_count, [31:29] zero
    logic                           m_tuser;   // [0] full_res

    // Local copy of the window: ring, write slot, fill level, running sum
    logic signed [rbma_pkg::SAMPLE_W-1:0] win_ring [WIN_DEPTH];
    int                                   win_wr;
    int                                   win_count;
    longint                               win_sum;

    mean_t       mean_q[$];      // results still owed by the block
    int unsigned error_count;
    int unsigned burst_left;     // words left in the current sender burst
    bit          tx_steady;      // suppress sender gaps
    bit          hold_off_req;   // ask the receiver for a long hold-off

    ring_buffer_moving_average_core #(
        .DEPTH(WIN_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offer one word from a falling edge, hold it until accepted, fold it
    // into the local window, then idle for a random gap at burst ends.
    // Return at a falling edge.
    task automatic send_word(input rbma_pkg::kind_t kind_in,
                             input logic [rbma_pkg::SAMPLE_W-1:0] smp);
        mean_t  m;
        longint q;
        s_tuser  = kind_in;
        s_tdata  = smp;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (kind_in == rbma_pkg::KIND_CLEAR) begin
            // Drop everything; ring contents stay but are never read
            // before being overwritten again.
            win_wr    = 0;
            win_count = 0;
            win_sum   = 0;
        end else begin
            if (win_count == WIN_DEPTH) begin
                // Full: retire the oldest sample in the slot being overwritten
                win_sum = win_sum - longint'(win_ring[win_wr]) + longint'(signed'(smp));
            end else begin
                win_sum   = win_sum + longint'(signed'(smp));
                win_count = win_count + 1;
            end
            win_ring[win_wr] = signed'(smp);
            win_wr = (win_wr == WIN_DEPTH - 1) ? 0 : win_wr + 1;
            // Signed divide truncates toward zero
            q = (win_sum * 256) / longint'(win_count);
            m.average    = q[rbma_pkg::AVG_W-1:0];
            m.held_count = win_count[rbma_pkg::CNT_OUT_W-1:0];
            m.full       = (win_count == WIN_DEPTH);
            mean_q.push_back(m);
        end
        @(negedge aclk);
        if (!tx_steady) begin
            if (burst_left == 0) begin
                // Drop valid and scribble on the data while idle
                s_tvalid = 1'b0;
                s_tdata  = rbma_pkg::S_TDATA_W'($urandom);
                s_tuser  = 1'($urandom);
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4))
                    @(negedge aclk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) :
                                                           $urandom_range(0, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Extremes, sign handling of truncation, an ignored sample on clear,
    // a full window at the negative limit and pointer wrap on overwrite.
    task automatic test_directed();
        int i;
        send_word(rbma_pkg::KIND_SAMPLE, 16'h7FFF);
        send_word(rbma_pkg::KIND_SAMPLE, 16'h8000);    // sum -1 over 2
        send_word(rbma_pkg::KIND_SAMPLE, 16'hFFFF);    // sum -2 over 3: truncate toward zero
        send_word(rbma_pkg::KIND_CLEAR,  16'h8001);    // sample field ignored
        for (i = 0; i < WIN_DEPTH; i++)
            send_word(rbma_pkg::KIND_SAMPLE, 16'h8000);   // fill to most negative mean
        for (i = 0; i < 3; i++)
            send_word(rbma_pkg::KIND_SAMPLE, 16'h7FFF);   // overwrite oldest, wrap pointer
        send_word(rbma_pkg::KIND_CLEAR,  16'hFFFF);
    endtask

    // Hold the receiver off while the sender keeps offering words back to
    // back, so the block fills its result slots and stalls its input.
    task automatic test_backpressure();
        int i;
        tx_steady    = 1'b1;
        hold_off_req = 1'b1;
        for (i = 0; i < 12; i++)
            send_word(($urandom_range(0, 7) == 0) ? rbma_pkg::KIND_CLEAR : rbma_pkg::KIND_SAMPLE,
                      rbma_pkg::SAMPLE_W'($urandom));
        tx_steady = 1'b0;
    endtask

    // Runs of samples, some from an empty window after a clear, some long
    // enough to wrap the ring several times, with assorted value styles.
    task automatic test_random_windows();
        int unsigned sent;
        int unsigned run;
        int unsigned style;
        logic [rbma_pkg::SAMPLE_W-1:0] base;
        logic [rbma_pkg::SAMPLE_W-1:0] smp;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 2) == 0) begin
                send_word(rbma_pkg::KIND_CLEAR, rbma_pkg::SAMPLE_W'($urandom));
                sent++;
            end
            run   = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 34);
            style = $urandom_range(0, 5);
            base  = rbma_pkg::SAMPLE_W'($urandom);
            repeat (run) begin
                case (style)
                    1:       smp = 16'h7FFF;
                    2:       smp = 16'h8000;
                    3:       smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    4:       smp = 16'($signed($urandom_range(0, 16)) - 8);
                    5:       smp = base;
                    default: smp = rbma_pkg::SAMPLE_W'($urandom);
                endcase
                send_word(rbma_pkg::KIND_SAMPLE, smp);
                sent++;
            end
        end
    endtask

    // Receiver: alternate ready runs and stall runs, with occasional long
    // stretches of steady ready; honor a hold-off request counted here.
    initial begin
        int unsigned rx_left;
        m_tready = 1'b0;
        rx_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                for (int unsigned c = 0; c < HOLD_OFF_CYCLES; c++)
                    @(negedge aclk);
                hold_off_req = 1'b0;
                rx_left      = 0;
            end
            if (rx_left == 0) begin
                if (m_tready && $urandom_range(0, 2) != 0) begin
                    m_tready = 1'b0;
                    rx_left  = $urandom_range(1, 40);
                end else begin
                    m_tready = 1'b1;
                    rx_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) :
                                                             $urandom_range(1, 30);
                end
            end
            rx_left--;
        end
    end

    // Monitor: match each accepted result word against the oldest owed one
    always @(posedge aclk) begin
        mean_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (mean_q.size() == 0) begin
                report_mismatch("result word with nothing owed", m_tdata, 0);
            end else begin
                want = mean_q.pop_front();
                if (m_tdata[rbma_pkg::AVG_W-1:0] !== want.average)
                    report_mismatch("average", m_tdata[rbma_pkg::AVG_W-1:0], want.average);
                if (m_tdata[rbma_pkg::AVG_W+rbma_pkg::CNT_OUT_W-1:rbma_pkg::AVG_W]
                        !== want.held_count)
                    report_mismatch("held_count",
                                    m_tdata[rbma_pkg::AVG_W+rbma_pkg::CNT_OUT_W-1:rbma_pkg::AVG_W],
                                    want.held_count);
                if (m_tdata[rbma_pkg::M_TDATA_W-1:rbma_pkg::AVG_W+rbma_pkg::CNT_OUT_W] !== '0)
                    report_mismatch("tdata padding",
                                    m_tdata[rbma_pkg::M_TDATA_W-1:rbma_pkg::AVG_W+rbma_pkg::CNT_OUT_W],
                                    0);
                if (m_tuser !== want.full)
                    report_mismatch("full_res", m_tuser, want.full);
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        #9_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        int wait_cycles;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        error_count  = 0;
        burst_left   = 0;
        tx_steady    = 1'b0;
        hold_off_req = 1'b0;
        win_wr       = 0;
        win_count    = 0;
        win_sum      = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_backpressure();
        test_random_windows();
        test_backpressure();

        s_tvalid = 1'b0;
        // Drain owed results, then give the divider time to show strays
        for (wait_cycles = 0; wait_cycles < 4000 && mean_q.size() != 0; wait_cycles++)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mean_q.size() != 0)
            report_mismatch("results never delivered", mean_q.size(), 0);

        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
